>>> hw/rtl/box_outline_pixel_writer_assert.svh
// Assertion macros for the box outline pixel writer checker.
// Depends on signals named clk and rst_n in the scope that uses the macros.
`ifndef BOX_OUTLINE_PIXEL_WRITER_ASSERT_SVH
`define BOX_OUTLINE_PIXEL_WRITER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BOPW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("box outline pixel writer check failed");

// The consequent must hold in the cycle after the antecedent.
`define BOPW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("box outline pixel writer check failed");

`endif

>>> hw/rtl/bopw_pkg.sv
// Shared types, constants, palette and microprogram of the box outline pixel writer.
// Has no dependencies; every other SystemVerilog file but the assertion macro header uses it.
`default_nettype none

package bopw_pkg;

  localparam int COORD_BITS_DEF  = 12;
  localparam int ADDR_BITS       = 25;
  localparam int IMG_W_BITS      = 13;
  localparam int BPP_BITS        = 3;
  localparam int COLOR_BITS      = 3;
  localparam int BYTE_COUNT_BITS = 2;
  localparam int CHAN_BITS       = 8;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 13;
  localparam int STEP_BITS       = 3;
  localparam int NUM_COLORS      = 6;

  localparam logic [IMG_W_BITS-1:0]      IMAGE_WIDTH_RST  = 13'd640;
  localparam logic [BPP_BITS-1:0]        BPP_RST          = 3'd3;
  localparam logic [COLOR_BITS-1:0]      COLOR_RST        = 3'd0;
  localparam logic [BYTE_COUNT_BITS-1:0] BYTE_COUNT_MAX   = 2'd3;
  localparam logic [1:0]                 SIDE_LEFT        = 2'd3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_IMAGE_WIDTH,
    REG_BYTES_PER_PIXEL,
    REG_COLOR_SELECT
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] red;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] blue;
  } rgb_t;

  localparam rgb_t PALETTE [NUM_COLORS] = '{
    '{8'd255, 8'd0,   8'd0  },
    '{8'd0,   8'd255, 8'd0  },
    '{8'd0,   8'd0,   8'd255},
    '{8'd0,   8'd255, 8'd255},
    '{8'd255, 8'd0,   8'd255},
    '{8'd255, 8'd255, 8'd0  }
  };

  typedef logic [STEP_BITS-1:0] step_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LATCH,
    OP_LOAD,
    OP_GEOM,
    OP_SUM,
    OP_SCALE,
    OP_EMIT
  } step_op_t;

  typedef enum logic [2:0] {
    JC_ALWAYS,
    JC_IN_VALID,
    JC_IS_TICK,
    JC_BUSY,
    JC_OUT_FREE
  } jump_cond_t;

  typedef struct packed {
    step_op_t   op;
    jump_cond_t cond;
    step_t      jump_true;
    step_t      jump_false;
  } ucode_t;

  localparam step_t ST_FETCH    = 3'd0;
  localparam step_t ST_DISPATCH = 3'd1;
  localparam step_t ST_LOAD     = 3'd2;
  localparam step_t ST_GEOM     = 3'd3;
  localparam step_t ST_SUM      = 3'd4;
  localparam step_t ST_SCALE    = 3'd5;
  localparam step_t ST_EMIT     = 3'd6;

  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    unique case (s)
      ST_FETCH:    w = '{OP_LATCH, JC_IN_VALID, ST_DISPATCH, ST_FETCH};
      ST_DISPATCH: w = '{OP_NONE,  JC_IS_TICK,  ST_GEOM,     ST_LOAD};
      ST_LOAD:     w = '{OP_LOAD,  JC_ALWAYS,   ST_EMIT,     ST_EMIT};
      ST_GEOM:     w = '{OP_GEOM,  JC_BUSY,     ST_SUM,      ST_EMIT};
      ST_SUM:      w = '{OP_SUM,   JC_ALWAYS,   ST_SCALE,    ST_SCALE};
      ST_SCALE:    w = '{OP_SCALE, JC_ALWAYS,   ST_EMIT,     ST_EMIT};
      ST_EMIT:     w = '{OP_EMIT,  JC_OUT_FREE, ST_FETCH,    ST_EMIT};
      default:     w = '{OP_NONE,  JC_ALWAYS,   ST_FETCH,    ST_FETCH};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bopw_if.sv
// Channel interfaces of the box outline pixel writer: command input, pixel write
// output and configuration write port. Depends on bopw_pkg.
`default_nettype none

interface bopw_in_if #(parameter int COORD_BITS = bopw_pkg::COORD_BITS_DEF);
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic signed [COORD_BITS-1:0] left_x;
  logic signed [COORD_BITS-1:0] top_y;
  logic signed [COORD_BITS-1:0] right_x;
  logic signed [COORD_BITS-1:0] bottom_y;

  modport source (output valid, cmd, left_x, top_y, right_x, bottom_y, input ready);
  modport sink (input valid, cmd, left_x, top_y, right_x, bottom_y, output ready);
endinterface

interface bopw_out_if;
  import bopw_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       write_valid;
  logic [ADDR_BITS-1:0]       byte_address;
  logic [BYTE_COUNT_BITS-1:0] byte_count;
  logic [CHAN_BITS-1:0]       red;
  logic [CHAN_BITS-1:0]       green;
  logic [CHAN_BITS-1:0]       blue;
  logic                       box_done;

  modport source (output valid, write_valid, byte_address, byte_count, red, green, blue,
                  box_done, input ready);
  modport sink (input valid, write_valid, byte_address, byte_count, red, green, blue,
                box_done, output ready);
endinterface

interface bopw_cfg_if;
  import bopw_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/box_outline_pixel_writer.sv
// Box outline pixel writer: microcoded sequencer and datapath that turn tick items
// into frame-buffer pixel writes. Depends on bopw_pkg and bopw_if.
//
// Usage. The in_ch channel carries one item per handshake: cmd 0 loads a box from
// its four corners and starts an outline up to two pixels thick, cmd 1 is a tick that asks
// for the next pixel write. Every accepted item yields exactly one item on out_ch;
// loads and ticks while idle give an item with write_valid low and all fields zero.
// The cfg_ch port writes image_width, bytes_per_pixel and color_select by index and
// is always ready; write it only while the block is idle.
// Sequence. A seven-step microprogram drives the datapath, one step per cycle, holding
// in its emit step while out_ch stalls. A tick that draws loads the output register after
// the dispatch, geometry, row multiply and add, bytes-per-pixel multiply and emit steps;
// a load after dispatch, load and emit, and an idle tick after dispatch, geometry and emit.
// One item is in flight at a time: a new item is accepted only after emit returns to fetch.
// Stalls. The result sits in an output register; the sequencer holds in its emit
// step while that register is still full, and the input waits until it moves on.
// Reset. Registers take their reset values, the block is idle and out_ch is empty.
`default_nettype none

module box_outline_pixel_writer #(
  parameter int COORD_BITS = bopw_pkg::COORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  bopw_in_if.sink       in_ch,
  bopw_out_if.source    out_ch,
  bopw_cfg_if.sink      cfg_ch
);
  import bopw_pkg::*;

  localparam int CW = COORD_BITS + 1;
  localparam int MW = CW + IMG_W_BITS;
  localparam int SW = ADDR_BITS + BPP_BITS;

  step_t  step_r;
  step_t  step_nxt;
  ucode_t ctl;
  logic   take;

  logic [IMG_W_BITS-1:0] width_r;
  logic [BPP_BITS-1:0]   bpp_r;
  logic [COLOR_BITS-1:0] color_r;

  logic                  cmd_r;
  logic [COORD_BITS-1:0] corner_r [4];
  logic                  busy_r;
  logic                  ok1_r;
  logic [2:0]            phase_r;
  logic [CW-1:0]         pos_r;

  logic [CW-1:0] pix_x_r;
  logic [CW-1:0] pix_y_r;
  logic [ADDR_BITS-1:0] prod_r;

  logic                       res_write_r;
  logic [ADDR_BITS-1:0]       res_addr_r;
  logic [BYTE_COUNT_BITS-1:0] res_cnt_r;
  rgb_t                       res_rgb_r;
  logic                       res_done_r;

  logic                       out_valid_r;
  logic                       out_write_r;
  logic [ADDR_BITS-1:0]       out_addr_r;
  logic [BYTE_COUNT_BITS-1:0] out_cnt_r;
  rgb_t                       out_rgb_r;
  logic                       out_done_r;
  logic                       out_free;

  logic          load_ok0;
  logic          load_ok1;
  logic [CW-1:0] dvec;
  logic [CW-1:0] rx1, ry1, rx2, ry2;
  logic          horiz;
  logic [CW-1:0] end_a, end_b, fixed_c, lo_c, hi_c, span_c, coord_c;
  logic          last_c;
  logic          finish_c;

  logic [MW-1:0]              mul_full;
  logic [SW-1:0]              scaled;
  logic [BYTE_COUNT_BITS-1:0] cnt_c;
  logic [COLOR_BITS-1:0]      color_idx;

  function automatic logic [CW-1:0] sx(logic [COORD_BITS-1:0] v);
    return {v[COORD_BITS-1], v};
  endfunction

  function automatic logic ge_minus_one(logic [COORD_BITS-1:0] v);
    return !v[COORD_BITS-1] || (v == '1);
  endfunction

  function automatic logic ge_one(logic [COORD_BITS-1:0] v);
    return !v[COORD_BITS-1] && (v != '0);
  endfunction

  assign ctl = ucode_rom(step_r);
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    case (ctl.cond)
      JC_ALWAYS:   take = 1'b1;
      JC_IN_VALID: take = in_ch.valid;
      JC_IS_TICK:  take = cmd_r;
      JC_BUSY:     take = busy_r;
      JC_OUT_FREE: take = out_free;
      default:     take = 1'b1;
    endcase
    step_nxt = take ? ctl.jump_true : ctl.jump_false;
  end

  assign load_ok0 = !corner_r[0][COORD_BITS-1] && !corner_r[1][COORD_BITS-1] &&
                    !corner_r[2][COORD_BITS-1] && !corner_r[3][COORD_BITS-1];
  assign load_ok1 = ge_minus_one(corner_r[0]) && ge_minus_one(corner_r[1]) &&
                    ge_one(corner_r[2]) && ge_one(corner_r[3]);

  always_comb begin
    dvec  = {{COORD_BITS{1'b0}}, phase_r[2]};
    rx1   = sx(corner_r[0]) + dvec;
    ry1   = sx(corner_r[1]) + dvec;
    rx2   = sx(corner_r[2]) - dvec;
    ry2   = sx(corner_r[3]) - dvec;
    horiz = !phase_r[0];
    end_a = horiz ? rx1 : ry1;
    end_b = horiz ? rx2 : ry2;
    case (phase_r[1:0])
      2'd0:    fixed_c = ry1;
      2'd1:    fixed_c = rx2;
      2'd2:    fixed_c = ry2;
      default: fixed_c = rx1;
    endcase
    if ($signed(end_a) < $signed(end_b)) begin
      lo_c = end_a;
      hi_c = end_b;
    end else begin
      lo_c = end_b;
      hi_c = end_a;
    end
    span_c   = hi_c - lo_c;
    coord_c  = lo_c + pos_r;
    last_c   = (pos_r == span_c);
    finish_c = last_c && (phase_r[1:0] == SIDE_LEFT) && !(!phase_r[2] && ok1_r);
  end

  assign mul_full  = MW'(pix_y_r) * MW'(width_r);
  assign scaled    = SW'(prod_r) * SW'(bpp_r);
  assign cnt_c     = (bpp_r < BPP_BITS'(BYTE_COUNT_MAX)) ? bpp_r[BYTE_COUNT_BITS-1:0]
                                                        : BYTE_COUNT_MAX;
  assign color_idx = (color_r < COLOR_BITS'(NUM_COLORS)) ? color_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_FETCH;
      width_r     <= IMAGE_WIDTH_RST;
      bpp_r       <= BPP_RST;
      color_r     <= COLOR_RST;
      busy_r      <= 1'b0;
      ok1_r       <= 1'b0;
      phase_r     <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_IMAGE_WIDTH:     width_r <= cfg_ch.data;
          REG_BYTES_PER_PIXEL: bpp_r   <= cfg_ch.data[BPP_BITS-1:0];
          REG_COLOR_SELECT:    color_r <= cfg_ch.data[COLOR_BITS-1:0];
          default: ;
        endcase
      end
      if (ctl.op == OP_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (ctl.op)
        OP_LOAD: begin
          pos_r   <= '0;
          ok1_r   <= load_ok1;
          busy_r  <= load_ok0 || load_ok1;
          phase_r <= (!load_ok0 && load_ok1) ? 3'd4 : 3'd0;
        end
        OP_GEOM: begin
          if (busy_r) begin
            if (!last_c) begin
              pos_r <= pos_r + CW'(1);
            end else begin
              pos_r <= '0;
              if (phase_r[1:0] != SIDE_LEFT) begin
                phase_r <= phase_r + 3'd1;
              end else if (!phase_r[2] && ok1_r) begin
                phase_r <= 3'd4;
              end else begin
                phase_r <= '0;
                busy_r  <= 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LATCH: begin
        if (in_ch.valid) begin
          cmd_r <= in_ch.cmd;
          if (!in_ch.cmd) begin
            corner_r[0] <= in_ch.left_x;
            corner_r[1] <= in_ch.top_y;
            corner_r[2] <= in_ch.right_x;
            corner_r[3] <= in_ch.bottom_y;
          end
        end
      end
      OP_LOAD: begin
        res_write_r <= 1'b0;
        res_addr_r  <= '0;
        res_cnt_r   <= '0;
        res_rgb_r   <= '0;
        res_done_r  <= 1'b0;
      end
      OP_GEOM: begin
        pix_x_r     <= horiz ? coord_c : fixed_c;
        pix_y_r     <= horiz ? fixed_c : coord_c;
        res_write_r <= busy_r;
        res_done_r  <= busy_r && finish_c;
        res_addr_r  <= '0;
        res_cnt_r   <= '0;
        res_rgb_r   <= '0;
      end
      OP_SUM: begin
        prod_r <= ADDR_BITS'(mul_full) + ADDR_BITS'(pix_x_r);
      end
      OP_SCALE: begin
        res_addr_r <= scaled[ADDR_BITS-1:0];
        res_cnt_r  <= cnt_c;
        res_rgb_r  <= PALETTE[color_idx];
      end
      OP_EMIT: begin
        if (out_free) begin
          out_write_r <= res_write_r;
          out_addr_r  <= res_addr_r;
          out_cnt_r   <= res_cnt_r;
          out_rgb_r   <= res_rgb_r;
          out_done_r  <= res_done_r;
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready         = (ctl.op == OP_LATCH);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.write_valid  = out_write_r;
  assign out_ch.byte_address = out_addr_r;
  assign out_ch.byte_count   = out_cnt_r;
  assign out_ch.red          = out_rgb_r.red;
  assign out_ch.green        = out_rgb_r.green;
  assign out_ch.blue         = out_rgb_r.blue;
  assign out_ch.box_done     = out_done_r;

endmodule

`default_nettype wire

>>> hw/rtl/bopw_checker.sv
// Port-level checker for the box outline pixel writer, attached by bind.
// Depends on bopw_pkg and box_outline_pixel_writer_assert.svh.
`default_nettype none
`include "box_outline_pixel_writer_assert.svh"

module bopw_checker (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 in_valid,
  input wire logic                                 in_ready,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic                                 out_write_valid,
  input wire logic [bopw_pkg::ADDR_BITS-1:0]       out_byte_address,
  input wire logic [bopw_pkg::BYTE_COUNT_BITS-1:0] out_byte_count,
  input wire logic                                 out_box_done
);
  import bopw_pkg::*;

  `BOPW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte_address))
  `BOPW_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  `BOPW_ASSERT_NOW(a_done_is_write, out_valid && out_box_done, out_write_valid)
  `BOPW_ASSERT_NOW(a_empty_is_zero, out_valid && !out_write_valid, out_byte_count == '0)

endmodule

bind box_outline_pixel_writer bopw_checker u_bopw_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_write_valid  (out_ch.write_valid),
  .out_byte_address (out_ch.byte_address),
  .out_byte_count   (out_ch.byte_count),
  .out_box_done     (out_ch.box_done)
);

`default_nettype wire

>>> tb/testbench.sv
// Testbench for box_outline_pixel_writer: loads boxes, ticks them out and checks every
// pixel write item against a built-in outline predictor, across several register settings.
// Depends on bopw_pkg, the bopw_if channel interfaces and the box_outline_pixel_writer RTL.
`timescale 1ns / 1ps

module testbench;
  import bopw_pkg::*;

  localparam int COORD_W = COORD_BITS_DEF;
  localparam int COORD_MAX = 2 ** (COORD_W - 1) - 1;
  localparam int COORD_MIN = -(2 ** (COORD_W - 1));
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 12;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_INDEX = 2'd3;

  localparam int SIDE_TOP = 0;
  localparam int SIDE_LEFT_LINE = 3;
  localparam int INNER_TOP_LINE = 4;
  localparam int SHADES = 6;
  localparam logic [23:0] SHADE_TABLE [SHADES] = '{
    24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h00FFFF, 24'hFF00FF, 24'hFFFF00
  };

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct {
    logic   cmd;
    coord_t left_x;
    coord_t top_y;
    coord_t right_x;
    coord_t bottom_y;
  } draw_cmd_t;

  typedef struct {
    logic                       write_valid;
    logic [ADDR_BITS-1:0]       byte_address;
    logic [BYTE_COUNT_BITS-1:0] byte_count;
    logic [CHAN_BITS-1:0]       red;
    logic [CHAN_BITS-1:0]       green;
    logic [CHAN_BITS-1:0]       blue;
    logic                       box_done;
  } pixel_write_t;

  logic clk = 1'b0;
  logic rst_n;

  bopw_in_if #(.COORD_BITS(COORD_W)) in_if ();
  bopw_out_if out_if ();
  bopw_cfg_if cfg_if ();

  box_outline_pixel_writer #(.COORD_BITS(COORD_W)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #6 clk = ~clk;

  int box_corner [4];
  int line_phase;
  int line_pos;
  bit box_busy;
  logic [IMG_W_BITS-1:0] cfg_width;
  logic [BPP_BITS-1:0]   cfg_bpp;
  logic [COLOR_BITS-1:0] cfg_color;

  pixel_write_t pending_writes [$];
  bit gaps_on;
  bit stalls_on;
  int failures;
  int items_sent;
  int writes_checked;
  int boxes_finished;
  int settings_applied;
  int quiet_cycles;

  function automatic bit rect_drawable(input int inset);
    return box_corner[0] + inset >= 0 && box_corner[1] + inset >= 0 &&
           box_corner[2] - inset >= 0 && box_corner[3] - inset >= 0;
  endfunction

  function automatic pixel_write_t predict_pixel_write(input draw_cmd_t c);
    pixel_write_t p;
    int inset, side, x1, y1, x2, y2, lo, hi, x, y;
    logic [31:0] xu, yu;
    logic [63:0] addr;
    logic [23:0] shade;
    p = '{default: '0};
    if (c.cmd == CMD_LOAD) begin
      box_corner[0] = int'(c.left_x);
      box_corner[1] = int'(c.top_y);
      box_corner[2] = int'(c.right_x);
      box_corner[3] = int'(c.bottom_y);
      line_pos = 0;
      if (rect_drawable(0)) begin
        line_phase = SIDE_TOP;
        box_busy = 1'b1;
      end else if (rect_drawable(1)) begin
        line_phase = INNER_TOP_LINE;
        box_busy = 1'b1;
      end else begin
        line_phase = SIDE_TOP;
        box_busy = 1'b0;
      end
      return p;
    end
    if (!box_busy) return p;
    inset = (line_phase >> 2) & 1;
    side = line_phase & 3;
    x1 = box_corner[0] + inset;
    y1 = box_corner[1] + inset;
    x2 = box_corner[2] - inset;
    y2 = box_corner[3] - inset;
    if (side == 0 || side == 2) begin
      lo = (x1 < x2) ? x1 : x2;
      hi = (x1 < x2) ? x2 : x1;
      x = lo + line_pos;
      y = (side == 0) ? y1 : y2;
    end else begin
      lo = (y1 < y2) ? y1 : y2;
      hi = (y1 < y2) ? y2 : y1;
      x = (side == 1) ? x2 : x1;
      y = lo + line_pos;
    end
    xu = x;
    yu = y;
    addr = (64'(yu) * 64'(cfg_width) + 64'(xu)) * 64'(cfg_bpp);
    shade = SHADE_TABLE[(cfg_color < SHADES) ? cfg_color : 0];
    p.write_valid = 1'b1;
    p.byte_address = addr[ADDR_BITS-1:0];
    p.byte_count = (cfg_bpp < 3) ? cfg_bpp[BYTE_COUNT_BITS-1:0] : BYTE_COUNT_MAX;
    {p.red, p.green, p.blue} = shade;
    if (line_pos < hi - lo) begin
      line_pos++;
    end else begin
      line_pos = 0;
      if (side != SIDE_LEFT_LINE) begin
        line_phase++;
      end else if (line_phase == SIDE_LEFT_LINE && rect_drawable(1)) begin
        line_phase = INNER_TOP_LINE;
      end else begin
        line_phase = SIDE_TOP;
        box_busy = 1'b0;
        p.box_done = 1'b1;
        boxes_finished++;
      end
    end
    return p;
  endfunction

  function automatic coord_t rand_coord();
    coord_t v;
    v = coord_t'($urandom());
    return v;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endfunction

  task automatic send_item(input logic cmd, input coord_t lx, input coord_t ty,
                           input coord_t rx, input coord_t by);
    draw_cmd_t item;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    item = '{cmd, lx, ty, rx, by};
    in_if.valid <= 1'b1;
    in_if.cmd <= cmd;
    in_if.left_x <= lx;
    in_if.top_y <= ty;
    in_if.right_x <= rx;
    in_if.bottom_y <= by;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_writes.push_back(predict_pixel_write(item));
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic run_box(input int lx, input int ty, input int rx,
                         input int by, input int max_ticks);
    int n;
    send_item(CMD_LOAD, coord_t'(lx), coord_t'(ty), coord_t'(rx), coord_t'(by));
    for (n = 0; n < max_ticks && box_busy; n++) send_tick();
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_writes.size() != 0);
  endtask

  task automatic apply_setting(input logic [IMG_W_BITS-1:0] width,
                               input logic [BPP_BITS-1:0] bpp,
                               input logic [COLOR_BITS-1:0] color, input bit poke_spare);
    logic [CFG_INDEX_BITS-1:0] idx [4];
    logic [CFG_DATA_BITS-1:0] val [4];
    int count;
    wait_drained();
    idx[0] = REG_IMAGE_WIDTH;
    val[0] = width;
    idx[1] = REG_BYTES_PER_PIXEL;
    val[1] = {10'($urandom()), bpp};
    idx[2] = REG_COLOR_SELECT;
    val[2] = {10'($urandom()), color};
    idx[3] = CFG_SPARE_INDEX;
    val[3] = CFG_DATA_BITS'($urandom());
    count = poke_spare ? 4 : 3;
    for (int k = 0; k < count; k++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[k];
      cfg_if.data <= val[k];
      @(posedge clk);
      while (!cfg_if.ready) @(posedge clk);
      case (idx[k])
        REG_IMAGE_WIDTH:     cfg_width = val[k];
        REG_BYTES_PER_PIXEL: cfg_bpp = val[k][BPP_BITS-1:0];
        REG_COLOR_SELECT:    cfg_color = val[k][COLOR_BITS-1:0];
        default: ;
      endcase
    end
    cfg_if.valid <= 1'b0;
    settings_applied++;
  endtask

  task automatic random_box_traffic(input int n_items);
    int stop_at, pick, span_x, span_y, bx, by, cx1, cx2, cy1, cy2;
    int c [4];
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      span_x = $urandom_range(0, 5);
      span_y = $urandom_range(0, 5);
      bx = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 0 : COORD_MAX - span_x)
                                       : $urandom_range(0, COORD_MAX - span_x);
      by = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 0 : COORD_MAX - span_y)
                                       : $urandom_range(0, COORD_MAX - span_y);
      if ($urandom_range(0, 1)) begin
        cx1 = bx;
        cx2 = bx + span_x;
      end else begin
        cx1 = bx + span_x;
        cx2 = bx;
      end
      if ($urandom_range(0, 1)) begin
        cy1 = by;
        cy2 = by + span_y;
      end else begin
        cy1 = by + span_y;
        cy2 = by;
      end
      if (pick < 68) begin
        run_box(cx1, cy1, cx2, cy2, 1000);
        repeat ($urandom_range(0, 1)) send_tick();
      end else if (pick < 78) begin
        c = '{cx1, cy1, cx2, cy2};
        c[$urandom_range(0, 3)] = $urandom_range(0, 1) ? -1 : -$urandom_range(1, 2048);
        run_box(c[0], c[1], c[2], c[3], 1000);
      end else if (pick < 90) begin
        run_box(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                $urandom_range(0, 24));
      end else begin
        repeat ($urandom_range(1, 6))
          send_item($urandom_range(0, 1) ? CMD_TICK : CMD_LOAD, rand_coord(), rand_coord(),
                    rand_coord(), rand_coord());
      end
    end
  endtask

  task automatic test_directed_cases();
    send_tick();
    run_box(0, 0, 0, 0, 10);
    run_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 2);
    run_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 1);
    run_box(-1, -1, 1, 1, 10);
    run_box(5, 4, 1, 0, 3);
  endtask

  task automatic test_register_sweep();
    apply_setting(13'd1, 3'd1, 3'd1, 1'b1);
    random_box_traffic(140);
    apply_setting(13'd4096, 3'd4, 3'd2, 1'b0);
    random_box_traffic(140);
    apply_setting(13'd0, 3'd0, 3'd3, 1'b0);
    random_box_traffic(140);
    apply_setting(13'd8191, 3'd7, 3'd4, 1'b1);
    random_box_traffic(140);
    apply_setting(13'd2, 3'd2, 3'd5, 1'b0);
    random_box_traffic(140);
    apply_setting(13'd4096, 3'd5, 3'd6, 1'b0);
    random_box_traffic(140);
    apply_setting(IMG_W_BITS'($urandom_range(1, 4096)), BPP_BITS'($urandom_range(1, 4)),
                  3'd7, 1'b0);
    random_box_traffic(140);
    apply_setting(13'd640, 3'd3, 3'd0, 1'b0);
    random_box_traffic(100);
  endtask

  task automatic test_drain_pauses();
    int k;
    for (k = 0; k < 4; k++) begin
      run_box(k, k, k + 4, k + 3, 5);
      wait_drained();
      while (box_busy) send_tick();
    end
  endtask

  task automatic test_calm_tail();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    apply_setting(IMG_W_BITS'($urandom_range(1, 4096)), BPP_BITS'($urandom_range(1, 4)),
                  COLOR_BITS'($urandom_range(0, 5)), 1'b0);
    random_box_traffic(100);
  endtask

  initial begin : out_ready_driver
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stalls_on && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : write_checker
    pixel_write_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_writes.size() == 0) begin
        $error("pixel write item arrived with nothing expected");
        failures++;
      end else begin
        want = pending_writes.pop_front();
        writes_checked++;
        check_field("write_valid", 32'(want.write_valid), 32'(out_if.write_valid));
        check_field("byte_address", 32'(want.byte_address), 32'(out_if.byte_address));
        check_field("byte_count", 32'(want.byte_count), 32'(out_if.byte_count));
        check_field("red", 32'(want.red), 32'(out_if.red));
        check_field("green", 32'(want.green), 32'(out_if.green));
        check_field("blue", 32'(want.blue), 32'(out_if.blue));
        check_field("box_done", 32'(want.box_done), 32'(out_if.box_done));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n !== 1'b1 || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a handshake", quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : main_sequence
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.cmd <= CMD_LOAD;
    in_if.left_x <= '0;
    in_if.top_y <= '0;
    in_if.right_x <= '0;
    in_if.bottom_y <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data <= '0;
    quiet_cycles = 0;
    failures = 0;
    items_sent = 0;
    writes_checked = 0;
    boxes_finished = 0;
    settings_applied = 0;
    box_corner = '{0, 0, 0, 0};
    line_phase = SIDE_TOP;
    line_pos = 0;
    box_busy = 1'b0;
    cfg_width = IMAGE_WIDTH_RST;
    cfg_bpp = BPP_RST;
    cfg_color = COLOR_RST;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_register_sweep();
    test_drain_pauses();
    test_calm_tail();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_writes.size() != 0) begin
      $error("%0d pixel write items never arrived", pending_writes.size());
      failures++;
    end
    $display("Run covered %0d items, %0d checked writes and %0d finished boxes,",
             items_sent, writes_checked, boxes_finished);
    $display("over %0d register settings with idle and stall bursts on both channels.",
             settings_applied);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/bopw_pkg.sv
hw/rtl/bopw_if.sv
hw/rtl/box_outline_pixel_writer.sv
hw/rtl/bopw_checker.sv
tb/testbench.sv
